// ===== hdl/uapq_pkg.sv =====
// Shared types and constants of the unsorted array priority queue.
package uapq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic signed [7:0] MIN_BOUND = 8'sd123;
    localparam logic signed [7:0] MAX_BOUND = 8'sd64;

    typedef enum logic [1:0] {
        MODE_ENQ   = 2'd0,
        MODE_DEQ   = 2'd1,
        MODE_FIND  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPACT,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [7:0]  value;
        logic signed [15:0] pri;
    } entry_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [7:0]  value;
        logic signed [15:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [10:0]        count;
        logic               best_valid;
        logic signed [7:0]  best_value;
        logic signed [15:0] best_priority;
        logic signed [7:0]  min_value;
        logic signed [7:0]  max_value;
        logic               found;
        logic [9:0]         found_index;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  best_pos;
        logic               best_valid;
        logic signed [7:0]  best_value;
        logic signed [15:0] best_pri;
        logic signed [7:0]  min_value;
        logic signed [7:0]  max_value;
        logic               found;
        logic [ADDR_W-1:0]  found_index;
    } scan_res_t;

endpackage

// ===== hdl/uapq_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
module uapq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/uapq_scan.sv =====
// Scan accumulator that tracks the best entry, the bounded minimum and maximum and the find hit.
module uapq_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic                          beat,
    input  uapq_pkg::entry_t              entry,
    input  logic [uapq_pkg::ADDR_W-1:0]   index,
    input  logic signed [7:0]             target,
    output uapq_pkg::scan_res_t           res
);

    logic                          have_reg, have_next;
    logic [uapq_pkg::ADDR_W-1:0]   pos_reg, pos_next;
    logic signed [7:0]             bval_reg, bval_next;
    logic signed [15:0]            bpri_reg, bpri_next;
    logic signed [7:0]             min_reg, min_next;
    logic signed [7:0]             max_reg, max_next;
    logic                          min_hit_reg, min_hit_next;
    logic                          max_hit_reg, max_hit_next;
    logic                          found_reg, found_next;
    logic [uapq_pkg::ADDR_W-1:0]   fidx_reg, fidx_next;
    logic                          better;

    always_comb
    begin
        better = !have_reg || (entry.pri > bpri_reg) ||
                 ((entry.pri == bpri_reg) && (entry.value > bval_reg));
        have_next    = have_reg;
        pos_next     = pos_reg;
        bval_next    = bval_reg;
        bpri_next    = bpri_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        min_hit_next = min_hit_reg;
        max_hit_next = max_hit_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        if (clear)
        begin
            have_next    = 1'b0;
            pos_next     = '0;
            bval_next    = '0;
            bpri_next    = '0;
            min_next     = uapq_pkg::MIN_BOUND;
            max_next     = uapq_pkg::MAX_BOUND;
            min_hit_next = 1'b0;
            max_hit_next = 1'b0;
            found_next   = 1'b0;
            fidx_next    = '0;
        end
        else if (beat)
        begin
            if (better)
            begin
                have_next = 1'b1;
                pos_next  = index;
                bval_next = entry.value;
                bpri_next = entry.pri;
            end
            if (entry.value < min_reg)
            begin
                min_next     = entry.value;
                min_hit_next = 1'b1;
            end
            if (entry.value > max_reg)
            begin
                max_next     = entry.value;
                max_hit_next = 1'b1;
            end
            if (entry.value == target)
            begin
                found_next = 1'b1;
                fidx_next  = index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 1'b0;
            pos_reg     <= '0;
            bval_reg    <= '0;
            bpri_reg    <= '0;
            min_reg     <= uapq_pkg::MIN_BOUND;
            max_reg     <= uapq_pkg::MAX_BOUND;
            min_hit_reg <= 1'b0;
            max_hit_reg <= 1'b0;
            found_reg   <= 1'b0;
            fidx_reg    <= '0;
        end
        else
        begin
            have_reg    <= have_next;
            pos_reg     <= pos_next;
            bval_reg    <= bval_next;
            bpri_reg    <= bpri_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            min_hit_reg <= min_hit_next;
            max_hit_reg <= max_hit_next;
            found_reg   <= found_next;
            fidx_reg    <= fidx_next;
        end
    end

    always_comb
    begin
        res.best_pos    = pos_reg;
        res.best_valid  = have_reg;
        res.best_value  = bval_reg;
        res.best_pri    = bpri_reg;
        res.min_value   = min_hit_reg ? min_reg : 8'sd0;
        res.max_value   = max_hit_reg ? max_reg : 8'sd0;
        res.found       = found_reg;
        res.found_index = fidx_reg;
    end

endmodule

// ===== hdl/unsorted_array_priority_queue.sv =====
// Top level of the unsorted array priority queue: control sequencer, entry memory and scan unit.
//
// The entries live in arrival order in one memory with a single read and a single write
// port, and every operation ends with a scan that reads each held entry once, one per
// cycle, to find the best entry, the bounded minimum and maximum and the find position.
// A dequeue first moves every entry behind the removed one down by one place, one entry
// per cycle through the same memory ports. The result waits in an output register, so
// the next request beat is accepted as soon as the sequencer returns to idle, even while
// the result is still stalled. Reset needs no memory clearing pass.
module unsorted_array_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  uapq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output uapq_pkg::rsp_t rsp
);

    localparam int AW = uapq_pkg::ADDR_W;
    localparam int CW = uapq_pkg::CNT_W;

    uapq_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    uapq_pkg::mode_t     mode_reg, mode_next;
    uapq_pkg::status_t   status_reg, status_next;
    logic signed [7:0]   target_reg, target_next;
    logic                out_valid_reg, out_valid_next;
    uapq_pkg::rsp_t      out_reg, out_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    uapq_pkg::entry_t    wr_data;
    logic                rd_en;
    uapq_pkg::entry_t    rd_data;
    logic                scan_clear;
    logic                scan_beat;
    uapq_pkg::scan_res_t scan_res;
    logic                reads_left;
    logic                find_hit;

    uapq_ram #(
        .DEPTH(uapq_pkg::CAPACITY),
        .WIDTH($bits(uapq_pkg::entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    uapq_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (scan_clear),
        .beat   (scan_beat),
        .entry  (rd_data),
        .index  (rd_idx_reg),
        .target (target_reg),
        .res    (scan_res)
    );

    assign req_stall  = (state_reg != uapq_pkg::S_IDLE);
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;
    assign reads_left = (ptr_reg < count_reg);
    assign scan_beat  = rd_pend_reg && (state_reg == uapq_pkg::S_SCAN);
    assign find_hit   = (mode_reg == uapq_pkg::MODE_FIND) && scan_res.found;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data.value  = req.value;
        wr_data.pri    = req.priority_req;
        rd_en          = 1'b0;
        scan_clear     = 1'b0;

        if (rsp_valid && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            uapq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    scan_clear  = 1'b1;
                    mode_next   = uapq_pkg::mode_t'(req.mode);
                    target_next = req.value;
                    status_next = uapq_pkg::ST_DONE;
                    ptr_next    = '0;
                    state_next  = uapq_pkg::S_SCAN;
                    case (uapq_pkg::mode_t'(req.mode))
                        uapq_pkg::MODE_ENQ:
                        begin
                            if (count_reg >= CW'(uapq_pkg::CAPACITY))
                            begin
                                status_next = uapq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        uapq_pkg::MODE_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = uapq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = CW'(scan_res.best_pos) + CW'(1);
                                state_next = uapq_pkg::S_COMPACT;
                            end
                        end
                        uapq_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            uapq_pkg::S_COMPACT:
            begin
                if (reads_left)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                end
                if (rd_pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (!reads_left && !rd_pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    ptr_next   = '0;
                    state_next = uapq_pkg::S_SCAN;
                end
            end

            uapq_pkg::S_SCAN:
            begin
                if (reads_left)
                begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                end
                if (!reads_left && !rd_pend_reg)
                begin
                    state_next = uapq_pkg::S_DONE;
                end
            end

            uapq_pkg::S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.status        = status_reg;
                    out_next.count         = 11'(count_reg);
                    out_next.best_valid    = scan_res.best_valid;
                    out_next.best_value    = scan_res.best_value;
                    out_next.best_priority = scan_res.best_pri;
                    out_next.min_value     = scan_res.min_value;
                    out_next.max_value     = scan_res.max_value;
                    out_next.found         = find_hit;
                    out_next.found_index   = find_hit ? 10'(scan_res.found_index) : 10'd0;
                    out_valid_next         = 1'b1;
                    state_next             = uapq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = uapq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uapq_pkg::S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= uapq_pkg::MODE_ENQ;
            status_reg    <= uapq_pkg::ST_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        target_reg <= target_next;
        out_reg    <= out_next;
    end

    // The entry count never grows beyond the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(uapq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    // A compaction write always lands inside the held part of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uapq_pkg::S_COMPACT) && rd_pend_reg
        |-> (rd_idx_reg != '0) && (CW'(rd_idx_reg) < count_reg))
        else $error("compaction write outside the held entries");

    // A result beat reports a best entry exactly when the table is not empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.best_valid == (rsp.count != 11'd0)))
        else $error("best entry flag disagrees with count");

    // An accepted request beat holds off the next one while it is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while an operation is in progress");

endmodule

// ===== sim/unsorted_array_priority_queue_tb.sv =====
// Self-checking testbench for the unsorted array priority queue, with a queue-based table predictor.
module unsorted_array_priority_queue_tb;
    import uapq_pkg::*;

    localparam int RANDOM_ITEMS = 156;
    localparam int DEEP_FILL = 100;
    localparam int TAIL_CYCLES = 2 * CAPACITY + 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    entry_t held_entries[$];
    rsp_t expected_rsps[$];

    bit steady_run;
    int error_count;
    int accepted_count;
    int checked_count;
    int full_refusals;
    int empty_refusals;
    int find_hits;
    int deepest_table;
    int cycle_count;

    unsorted_array_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int best_slot();
        int b;
        b = 0;
        for (int i = 1; i < held_entries.size(); i++)
        begin
            if ($signed(held_entries[i].pri) > $signed(held_entries[b].pri) ||
                ($signed(held_entries[i].pri) == $signed(held_entries[b].pri) &&
                 $signed(held_entries[i].value) > $signed(held_entries[b].value)))
                b = i;
        end
        return b;
    endfunction

    function automatic rsp_t predict_table_rsp(input req_t r);
        rsp_t o;
        entry_t e;
        int b;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        o = '0;
        case (r.mode)
            MODE_ENQ:
            begin
                if (held_entries.size() >= CAPACITY)
                begin
                    o.status = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    e.value = r.value;
                    e.pri = r.priority_req;
                    held_entries.push_back(e);
                end
            end
            MODE_DEQ:
            begin
                if (held_entries.size() == 0)
                begin
                    o.status = ST_EMPTY;
                    empty_refusals++;
                end
                else
                    held_entries.delete(best_slot());
            end
            MODE_FIND:
            begin
                for (int i = 0; i < held_entries.size(); i++)
                begin
                    if (held_entries[i].value == r.value)
                    begin
                        o.found = 1'b1;
                        o.found_index = 10'(i);
                    end
                end
                if (o.found)
                    find_hits++;
            end
            default:
                held_entries.delete();
        endcase
        o.count = 11'(held_entries.size());
        if (held_entries.size() > 0)
        begin
            b = best_slot();
            o.best_valid = 1'b1;
            o.best_value = held_entries[b].value;
            o.best_priority = held_entries[b].pri;
        end
        lo = MIN_BOUND;
        hi = MAX_BOUND;
        for (int i = 0; i < held_entries.size(); i++)
        begin
            if ($signed(held_entries[i].value) < lo)
            begin
                lo = held_entries[i].value;
                o.min_value = lo;
            end
            if ($signed(held_entries[i].value) > hi)
            begin
                hi = held_entries[i].value;
                o.max_value = hi;
            end
        end
        if (held_entries.size() > deepest_table)
            deepest_table = held_entries.size();
        return o;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
            flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
                flag_error("result beat with no request outstanding");
            else
            begin
                want = expected_rsps.pop_front();
                checked_count++;
                check_field("status", want.status, rsp.status);
                check_field("count", want.count, rsp.count);
                check_field("best_valid", want.best_valid, rsp.best_valid);
                check_field("best_value", $signed(want.best_value), $signed(rsp.best_value));
                check_field("best_priority", $signed(want.best_priority),
                            $signed(rsp.best_priority));
                check_field("min_value", $signed(want.min_value), $signed(rsp.min_value));
                check_field("max_value", $signed(want.max_value), $signed(rsp.max_value));
                check_field("found", want.found, rsp.found);
                check_field("found_index", want.found_index, rsp.found_index);
            end
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall = !steady_run && ($urandom_range(99) < 22);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Cycle limit reached with %0d results outstanding.", expected_rsps.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Called at a falling edge; valid stays high after the beat, so back-to-back requests
    // keep it high unless a random gap is inserted outside the steady run.
    task automatic send_req(input mode_t m, input logic signed [7:0] v,
                            input logic signed [15:0] p);
        if (!steady_run && $urandom_range(99) < 22)
        begin
            req_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 22);
        end
        req.mode = m;
        req.value = v;
        req.priority_req = p;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsps.push_back(predict_table_rsp(req));
        accepted_count++;
        @(negedge clk);
    endtask

    task automatic wait_results();
        req_valid = 1'b0;
        while (expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [7:0] rand_value();
        case ($urandom_range(15))
            0: return 8'sh80;
            1: return 8'sh7F;
            2: return 8'sd0;
            3: return -8'sd1;
            4: return 8'sd64;
            5: return 8'sd65;
            6: return 8'sd122;
            7: return 8'sd123;
            8, 9: return 8'($urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_priority();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd0;
            3: return -16'sd1;
            4, 5: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_empty_table();
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_FIND, 8'sd0, 16'sd0);
        send_req(MODE_CLEAR, 8'sd5, 16'sd5);
        send_req(MODE_DEQ, 8'sh7F, 16'sh7FFF);
    endtask

    task automatic test_priority_order();
        send_req(MODE_ENQ, 8'sd5, 16'sd100);
        send_req(MODE_ENQ, 8'sh80, 16'sh8000);
        send_req(MODE_ENQ, 8'sd10, 16'sh7FFF);
        send_req(MODE_ENQ, 8'sh7F, 16'sh7FFF);
        send_req(MODE_ENQ, 8'sh7F, 16'sh7FFF);
        send_req(MODE_ENQ, 8'sh80, 16'sh7FFF);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_FIND, 8'sh7F, 16'sd0);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_CLEAR, 8'sd0, 16'sd0);
    endtask

    task automatic test_find_and_bounds();
        send_req(MODE_ENQ, 8'sd123, 16'sd1);
        send_req(MODE_ENQ, 8'sd64, 16'sd1);
        send_req(MODE_ENQ, 8'sd122, -16'sd1);
        send_req(MODE_ENQ, 8'sd65, 16'sd2);
        send_req(MODE_ENQ, -8'sd1, 16'sd2);
        send_req(MODE_ENQ, 8'sd65, 16'sd0);
        send_req(MODE_FIND, 8'sd65, 16'sd0);
        send_req(MODE_FIND, 8'sd123, 16'sd0);
        send_req(MODE_FIND, 8'sd0, 16'sd0);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_CLEAR, 8'sd0, 16'sd0);
    endtask

    task automatic test_deep_table();
        logic signed [7:0] last_value;
        last_value = 8'sd0;
        for (int i = 0; i < DEEP_FILL; i++)
        begin
            last_value = rand_value();
            send_req(MODE_ENQ, last_value, 16'($urandom));
        end
        send_req(MODE_ENQ, 8'sd1, 16'sd1);
        send_req(MODE_FIND, last_value, 16'sd0);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_ENQ, 8'sh7F, 16'sh7FFF);
        send_req(MODE_ENQ, 8'sh80, 16'sh8000);
        send_req(MODE_DEQ, 8'sd0, 16'sd0);
        send_req(MODE_CLEAR, 8'sd0, 16'sd0);
    endtask

    task automatic test_random_traffic();
        int pick;
        mode_t m;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_run = (n >= 40 && n < 90);
            if (n == 110)
                wait_results();
            pick = $urandom_range(99);
            if (pick < 3)
                m = MODE_CLEAR;
            else if (held_entries.size() > 40)
            begin
                if (pick < 60)
                    m = MODE_DEQ;
                else if (pick < 75)
                    m = MODE_FIND;
                else
                    m = MODE_ENQ;
            end
            else if (pick < 55)
                m = MODE_ENQ;
            else if (pick < 80)
                m = MODE_DEQ;
            else
                m = MODE_FIND;
            send_req(m, rand_value(), rand_priority());
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        steady_run = 1'b0;
        error_count = 0;
        accepted_count = 0;
        checked_count = 0;
        full_refusals = 0;
        empty_refusals = 0;
        find_hits = 0;
        deepest_table = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_priority_order();
        test_find_and_bounds();
        test_deep_table();
        test_random_traffic();

        wait_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_rsps.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_rsps.size()));

        $display("Checked %0d result beats for %0d requests; deepest table %0d entries.",
                 checked_count, accepted_count, deepest_table);
        $display("Refused enqueues %0d, refused dequeues %0d, find hits %0d, errors %0d.",
                 full_refusals, empty_refusals, find_hits, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
